// ----- rtl/dtl_pkg.sv -----
// dtl_pkg: shared constants, types and elaboration-time table functions for the
// degree trig lookup block. No dependencies.
`timescale 1ns / 1ps

package dtl_pkg;

  localparam int FractionBitsDef = 16;
  localparam int AngleW          = 32;
  localparam int ValueW          = 32;
  localparam int KindW           = 2;
  localparam int NumBytes        = AngleW / 8;
  localparam int Modulus         = 360;
  localparam int HalfTurn        = 180;
  localparam int QuarterTurn     = 90;
  localparam int ThreeQuarter    = 270;
  localparam int RomDepth        = 91;
  localparam int ResW            = 9;   // residue 0..359
  localparam int IdxW            = 7;   // ROM index 0..90
  localparam int SineW           = 25;  // room for 2^24

  typedef enum logic [KindW-1:0] {
    KindSin = 2'd0,
    KindCos = 2'd1,
    KindTan = 2'd2,
    KindRsv = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  bad;
  } ctrl_t;

  typedef struct packed {
    logic            neg;
    logic [IdxW-1:0] idx;
  } fold_t;

  // Residue mod 360 of one byte's contribution; the top byte is signed.
  function automatic logic [ResW-1:0] byte_residue(input int pos, input int b);
    longint v;
    v = longint'(b);
    if ((pos == NumBytes - 1) && (b >= 128)) begin
      v = v - 256;
    end
    v = v * (longint'(1) << (8 * pos));
    v = v % Modulus;
    if (v < 0) begin
      v = v + Modulus;
    end
    return ResW'(v);
  endfunction

  // sin(d degrees) scaled by 2^frac, rounded to nearest.
  function automatic logic [SineW-1:0] sine_entry(input int d, input int frac);
    real    x;
    real    scaled;
    longint e;
    x      = $sin(real'(d) * 3.14159265358979323846 / 180.0);
    scaled = x * (2.0 ** frac);
    e      = longint'($floor(scaled + 0.5));
    if (e > (longint'(1) << frac)) begin
      e = longint'(1) << frac;
    end
    return SineW'(e);
  endfunction

  // Sum of two residues, brought back below 360.
  function automatic logic [ResW-1:0] mod_add(input logic [ResW-1:0] a,
                                               input logic [ResW-1:0] b);
    logic [ResW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= (ResW + 1)'(Modulus)) ? ResW'(s - (ResW + 1)'(Modulus)) : ResW'(s);
  endfunction

  // Fold 0..359 onto the quarter wave: index 0..90 and a sign.
  function automatic fold_t fold_angle(input logic [ResW-1:0] r);
    fold_t           f;
    logic [ResW-1:0] h;
    f.neg = (r > ResW'(HalfTurn));
    h     = f.neg ? (r - ResW'(HalfTurn)) : r;
    f.idx = (h > ResW'(QuarterTurn)) ? IdxW'(ResW'(HalfTurn) - h) : IdxW'(h);
    return f;
  endfunction

endpackage

// ----- rtl/dtl_reduce.sv -----
// dtl_reduce: three-stage reduction of a signed 32-bit angle modulo 360.
// Depends on dtl_pkg (residue tables, modular add).
`timescale 1ns / 1ps

module dtl_reduce (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  dtl_pkg::kind_e             kind_i,
  input  logic [dtl_pkg::AngleW-1:0] angle_i,
  output logic                       valid_o,
  output dtl_pkg::kind_e             kind_o,
  output logic [dtl_pkg::ResW-1:0]   res_o
);

  localparam int NB = dtl_pkg::NumBytes;
  localparam int RW = dtl_pkg::ResW;

  logic [RW-1:0] res_tab [NB][256];

  for (genvar p = 0; p < NB; p++) begin : g_tab
    for (genvar b = 0; b < 256; b++) begin : g_ent
      assign res_tab[p][b] = dtl_pkg::byte_residue(p, b);
    end
  end

  logic [RW-1:0]  byte_res_d [NB];
  logic [RW-1:0]  byte_res_q [NB];
  logic [RW-1:0]  pair_d     [2];
  logic [RW-1:0]  pair_q     [2];
  logic [RW-1:0]  res_d, res_q;
  logic           v1_q, v2_q, v3_q;
  dtl_pkg::kind_e kind1_q, kind2_q, kind3_q;

  always_comb begin
    for (int p = 0; p < NB; p++) begin
      byte_res_d[p] = res_tab[p][angle_i[8*p +: 8]];
    end
    pair_d[0] = dtl_pkg::mod_add(byte_res_q[0], byte_res_q[1]);
    pair_d[1] = dtl_pkg::mod_add(byte_res_q[2], byte_res_q[3]);
    res_d     = dtl_pkg::mod_add(pair_q[0], pair_q[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byte_res_q <= byte_res_d;
      kind1_q    <= kind_i;
      pair_q     <= pair_d;
      kind2_q    <= kind1_q;
      res_q      <= res_d;
      kind3_q    <= kind2_q;
    end
  end

  assign valid_o = v3_q;
  assign kind_o  = kind3_q;
  assign res_o   = res_q;

endmodule

// ----- rtl/dtl_fold_rom.sv -----
// dtl_fold_rom: quarter-wave fold of the sine and cosine angles, then the
// sine ROM read. Two register stages. Depends on dtl_pkg.
`timescale 1ns / 1ps

module dtl_fold_rom #(
  parameter int FractionBits = dtl_pkg::FractionBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  dtl_pkg::kind_e             kind_i,
  input  logic [dtl_pkg::ResW-1:0]   res_i,
  output logic                       valid_o,
  output dtl_pkg::ctrl_t             ctrl_o,
  output logic [FractionBits:0]      mag_s_o,
  output logic [FractionBits:0]      mag_c_o,
  output logic                       neg_o,     // sign of the tangent
  output logic [dtl_pkg::ValueW-1:0] direct_o   // sine or cosine result
);

  localparam int MagW = FractionBits + 1;
  localparam int RW   = dtl_pkg::ResW;
  localparam int VW   = dtl_pkg::ValueW;

  logic [MagW-1:0] rom [dtl_pkg::RomDepth];

  for (genvar d = 0; d < dtl_pkg::RomDepth; d++) begin : g_rom
    assign rom[d] = MagW'(dtl_pkg::sine_entry(d, FractionBits));
  end

  // Fold stage
  logic [RW-1:0]   rc;
  dtl_pkg::fold_t  fs_d, fc_d, fs_q, fc_q;
  dtl_pkg::ctrl_t  ctrl_d, ctrl4_q, ctrl5_q;
  logic            quarter;
  logic            v4_q, v5_q;

  // ROM stage
  logic [MagW-1:0] ms_d, mc_d, ms_q, mc_q;
  logic [MagW-1:0] sel_mag;
  logic            sel_neg;
  logic [VW-1:0]   direct_d, direct_q;
  logic            neg_q;

  always_comb begin
    // cosine angle: (r + 90) mod 360
    rc = (res_i >= RW'(dtl_pkg::ThreeQuarter)) ? (res_i - RW'(dtl_pkg::ThreeQuarter))
                                               : (res_i + RW'(dtl_pkg::QuarterTurn));
    fs_d = dtl_pkg::fold_angle(res_i);
    fc_d = dtl_pkg::fold_angle(rc);
    quarter = (res_i == '0) || (res_i == RW'(dtl_pkg::QuarterTurn)) ||
              (res_i == RW'(dtl_pkg::HalfTurn)) || (res_i == RW'(dtl_pkg::ThreeQuarter));
    ctrl_d.kind = kind_i;
    ctrl_d.bad  = (kind_i == dtl_pkg::KindRsv) || ((kind_i == dtl_pkg::KindTan) && quarter);

    ms_d = rom[fs_q.idx];
    mc_d = rom[fc_q.idx];
    if (ctrl4_q.kind == dtl_pkg::KindCos) begin
      sel_mag = mc_d;
      sel_neg = fc_q.neg;
    end else begin
      sel_mag = ms_d;
      sel_neg = fs_q.neg;
    end
    direct_d = sel_neg ? (VW'(0) - VW'(sel_mag)) : VW'(sel_mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= valid_i;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fs_q     <= fs_d;
      fc_q     <= fc_d;
      ctrl4_q  <= ctrl_d;
      ms_q     <= ms_d;
      mc_q     <= mc_d;
      neg_q    <= fs_q.neg ^ fc_q.neg;
      direct_q <= direct_d;
      ctrl5_q  <= ctrl4_q;
    end
  end

  assign valid_o  = v5_q;
  assign ctrl_o   = ctrl5_q;
  assign mag_s_o  = ms_q;
  assign mag_c_o  = mc_q;
  assign neg_o    = neg_q;
  assign direct_o = direct_q;

endmodule

// ----- rtl/dtl_div.sv -----
// dtl_div: pipelined restoring divider, one quotient bit per stage, giving
// (|sine| << FractionBits) / |cosine|. Carries the side payload alongside.
// Depends on dtl_pkg.
`timescale 1ns / 1ps

module dtl_div #(
  parameter int FractionBits = dtl_pkg::FractionBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  dtl_pkg::ctrl_t             ctrl_i,
  input  logic [FractionBits:0]      mag_s_i,
  input  logic [FractionBits:0]      mag_c_i,
  input  logic                       neg_i,
  input  logic [dtl_pkg::ValueW-1:0] direct_i,
  output logic                       valid_o,
  output dtl_pkg::ctrl_t             ctrl_o,
  output logic [2*FractionBits:0]    quo_o,
  output logic                       neg_o,
  output logic [dtl_pkg::ValueW-1:0] direct_o
);

  localparam int MagW = FractionBits + 1;
  localparam int NumW = 2 * FractionBits + 1;
  localparam int VW   = dtl_pkg::ValueW;

  logic                 vld_q    [NumW];
  dtl_pkg::ctrl_t       ctrl_q   [NumW];
  logic [MagW-1:0]      rem_q    [NumW];
  logic [NumW-1:0]      work_q   [NumW];
  logic [MagW-1:0]      den_q    [NumW];
  logic                 neg_q    [NumW];
  logic [VW-1:0]        direct_q [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic            vld_in;
    dtl_pkg::ctrl_t  ctrl_in;
    logic [MagW-1:0] rem_in;
    logic [NumW-1:0] work_in;
    logic [MagW-1:0] den_in;
    logic            neg_in;
    logic [VW-1:0]   direct_in;
    logic [MagW:0]   trial;
    logic            ge;

    if (k == 0) begin : g_head
      assign vld_in    = valid_i;
      assign ctrl_in   = ctrl_i;
      assign rem_in    = '0;
      assign work_in   = {mag_s_i, {FractionBits{1'b0}}};
      assign den_in    = mag_c_i;
      assign neg_in    = neg_i;
      assign direct_in = direct_i;
    end else begin : g_body
      assign vld_in    = vld_q[k-1];
      assign ctrl_in   = ctrl_q[k-1];
      assign rem_in    = rem_q[k-1];
      assign work_in   = work_q[k-1];
      assign den_in    = den_q[k-1];
      assign neg_in    = neg_q[k-1];
      assign direct_in = direct_q[k-1];
    end

    assign trial = {rem_in, work_in[NumW-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctrl_q[k]   <= ctrl_in;
        rem_q[k]    <= ge ? MagW'(trial - {1'b0, den_in}) : MagW'(trial);
        work_q[k]   <= {work_in[NumW-2:0], ge};
        den_q[k]    <= den_in;
        neg_q[k]    <= neg_in;
        direct_q[k] <= direct_in;
      end
    end
  end

  assign valid_o  = vld_q[NumW-1];
  assign ctrl_o   = ctrl_q[NumW-1];
  assign quo_o    = work_q[NumW-1];
  assign neg_o    = neg_q[NumW-1];
  assign direct_o = direct_q[NumW-1];

endmodule

// ----- rtl/degree_trig_lookup_core.sv -----
// degree_trig_lookup_core: sine, cosine and tangent of whole-degree angles
// from a quarter-wave sine ROM. Top level; uses dtl_pkg, dtl_reduce,
// dtl_fold_rom and dtl_div.
//
// Usage:
//   Input stream: s_axis_tdata_i carries the signed angle in degrees,
//   s_axis_tuser_i the function (sine, cosine, tangent). Output stream:
//   m_axis_tdata_o carries the signed fixed-point result with FractionBits
//   fraction bits, m_axis_tuser_o the invalid flag (tangent at a multiple of
//   90 degrees, or the unused function code; the value is then zero).
//   Every input transfer yields exactly one output transfer, in order.
//   Pipeline: three stages reduce the angle mod 360, two fold it and read
//   the ROM, 2*FractionBits + 1 form the tangent quotient one bit per stage,
//   and one is the output register. Sine and cosine ride the same pipe, so
//   order and latency are the same for all functions.
//   Throughput: one transfer per cycle while the receiver does not stall.
//   Reset clears all valid bits; the ROM is constant, no warm-up is needed.
//   When the receiver stalls with a result held, the whole pipe freezes and
//   s_axis_tready_o drops with it; nothing is lost or repeated.
`timescale 1ns / 1ps

module degree_trig_lookup_core #(
  parameter int FractionBits = dtl_pkg::FractionBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [dtl_pkg::AngleW-1:0]  s_axis_tdata_i,  // [31:0] angle_degrees
  input  logic [dtl_pkg::KindW-1:0]   s_axis_tuser_i,  // [1:0] kind
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [dtl_pkg::ValueW-1:0]  m_axis_tdata_o,  // [31:0] value
  output logic                        m_axis_tuser_o   // [0] invalid
);

  localparam int MagW  = FractionBits + 1;
  localparam int NumW  = 2 * FractionBits + 1;
  localparam int VW    = dtl_pkg::ValueW;
  localparam int QExtW = (NumW > VW + 1) ? NumW : VW + 1;

  localparam logic [QExtW-1:0] PosLimit = {{(QExtW - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
  localparam logic [QExtW-1:0] NegLimit = PosLimit + QExtW'(1);

  logic                 en;
  logic                 red_vld;
  dtl_pkg::kind_e       red_kind;
  logic [dtl_pkg::ResW-1:0] red_res;

  logic                 rom_vld;
  dtl_pkg::ctrl_t       rom_ctrl;
  logic [MagW-1:0]      rom_ms, rom_mc;
  logic                 rom_neg;
  logic [VW-1:0]        rom_direct;

  logic                 div_vld;
  dtl_pkg::ctrl_t       div_ctrl;
  logic [NumW-1:0]      div_quo;
  logic                 div_neg;
  logic [VW-1:0]        div_direct;

  logic [QExtW-1:0]     qx, qsat, qsigned;
  logic [VW-1:0]        value_d, value_q;
  logic                 bad_q;
  logic                 out_vld_q;

  // Whole-pipe advance: output register free or being drained this cycle.
  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  dtl_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .kind_i  (dtl_pkg::kind_e'(s_axis_tuser_i)),
    .angle_i (s_axis_tdata_i),
    .valid_o (red_vld),
    .kind_o  (red_kind),
    .res_o   (red_res)
  );

  dtl_fold_rom #(
    .FractionBits (FractionBits)
  ) u_fold_rom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (red_vld),
    .kind_i   (red_kind),
    .res_i    (red_res),
    .valid_o  (rom_vld),
    .ctrl_o   (rom_ctrl),
    .mag_s_o  (rom_ms),
    .mag_c_o  (rom_mc),
    .neg_o    (rom_neg),
    .direct_o (rom_direct)
  );

  dtl_div #(
    .FractionBits (FractionBits)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (rom_vld),
    .ctrl_i   (rom_ctrl),
    .mag_s_i  (rom_ms),
    .mag_c_i  (rom_mc),
    .neg_i    (rom_neg),
    .direct_i (rom_direct),
    .valid_o  (div_vld),
    .ctrl_o   (div_ctrl),
    .quo_o    (div_quo),
    .neg_o    (div_neg),
    .direct_o (div_direct)
  );

  // Tangent: saturate the magnitude to the signed 32-bit range, then apply sign.
  always_comb begin
    qx = QExtW'(div_quo);
    if (div_neg) begin
      qsat    = (qx > NegLimit) ? NegLimit : qx;
      qsigned = QExtW'(0) - qsat;
    end else begin
      qsat    = (qx > PosLimit) ? PosLimit : qx;
      qsigned = qsat;
    end
    if (div_ctrl.bad) begin
      value_d = '0;
    end else if (div_ctrl.kind == dtl_pkg::KindTan) begin
      value_d = qsigned[VW-1:0];
    end else begin
      value_d = div_direct;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      value_q <= value_d;
      bad_q   <= div_ctrl.bad;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = value_q;
  assign m_axis_tuser_o  = bad_q;

endmodule
